FILE: rtl/core/tmrle_pkg.sv
// shared types and constants for the two-marker run-length frame decoder
// no dependencies
`default_nettype none

package tmrle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned FRAME_W = 17;
    localparam int unsigned FRAME_MAX_CODE = (1 << FRAME_W) - 1;
    localparam logic [FRAME_W-1:0] FRAME_SIZE_RST = 17'd4096;

    typedef enum logic [7:0] {
        PH_FILL    = 8'b0000_0001,
        PH_MARK_A  = 8'b0000_0010,
        PH_MARK_B  = 8'b0000_0100,
        PH_TOKEN   = 8'b0000_1000,
        PH_A_COUNT = 8'b0001_0000,
        PH_B_COUNT = 8'b0010_0000,
        PH_B_VALUE = 8'b0100_0000,
        PH_FULL    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  length;
        logic              full;
    } t_run;

endpackage

`default_nettype wire

FILE: rtl/core/two_marker_rle_frame_decoder.sv
// two-marker run-length frame decoder, top level with register port
// depends on tmrle_pkg, tmrle_tok, tmrle_out
//
// input channel: one compressed byte per transfer (i_in_valid, o_in_stall),
// header bytes first (fill value, marker a, marker b), i_stream_end on the
// last byte of a frame returns the decoder to the header phase
// output channel: one (value, length, frame full) run per transfer
// (o_out_valid, i_out_stall); a byte that completes no run gives nothing
// a run is registered and shown in the cycle after the byte that completes it
// throughput: one byte per cycle unless stalled, set by the single result register
// o_in_stall rises only while a result is held and the receiver stalls
// frame_size at byte address 0 of the register port resets to 4096; the size
// in use saturates at MAX_FRAME_BYTES; write it only while the block is idle
// reset: synchronous, clears the phase, written count and result valid
`default_nettype none

module two_marker_rle_frame_decoder #(
    parameter int unsigned MAX_FRAME_BYTES = 65536
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output wire logic                         o_in_stall,
    input  wire logic [tmrle_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic                         i_stream_end,
    output wire logic                         o_out_valid,
    input  wire logic                         i_out_stall,
    output wire logic [tmrle_pkg::BYTE_W-1:0]  o_run_value,
    output wire logic [tmrle_pkg::LEN_W-1:0]   o_run_length,
    output wire logic                         o_frame_full,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output wire logic [31:0]                  prdata,
    output wire logic                         pready
);
    import tmrle_pkg::*;

    localparam int unsigned SIZE_CAP =
        (MAX_FRAME_BYTES > FRAME_MAX_CODE) ? FRAME_MAX_CODE : MAX_FRAME_BYTES;

    logic [FRAME_W-1:0] r_frame_size;
    logic [FRAME_W-1:0] size_eff;
    logic               busy;
    logic               take;
    logic               reg_hit;
    t_run               run;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == 1'b0);
    assign prdata  = reg_hit ? {{(32-FRAME_W){1'b0}}, r_frame_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_size <= FRAME_SIZE_RST;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_frame_size <= pwdata[FRAME_W-1:0];
        end
    end

    always_comb begin
        if (32'(r_frame_size) > SIZE_CAP) begin
            size_eff = FRAME_W'(SIZE_CAP);
        end else begin
            size_eff = r_frame_size;
        end
    end

    assign o_in_stall = busy;
    assign take       = i_in_valid & ~busy;

    tmrle_tok u_tok (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_in_byte    (i_in_byte),
        .i_stream_end (i_stream_end),
        .i_size       (size_eff),
        .o_run        (run)
    );

    tmrle_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_run        (run),
        .i_out_stall  (i_out_stall),
        .o_busy       (busy),
        .o_out_valid  (o_out_valid),
        .o_run_value  (o_run_value),
        .o_run_length (o_run_length),
        .o_frame_full (o_frame_full)
    );

endmodule

`default_nettype wire

FILE: rtl/core/tmrle_tok.sv
// token decoder: header capture, marker matching and run clipping
// depends on tmrle_pkg
`default_nettype none

module tmrle_tok (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_take,
    input  wire logic [tmrle_pkg::BYTE_W-1:0]  i_in_byte,
    input  wire logic                         i_stream_end,
    input  wire logic [tmrle_pkg::FRAME_W-1:0] i_size,
    output tmrle_pkg::t_run                   o_run
);
    import tmrle_pkg::*;

    t_phase              r_phase, n_phase;
    logic [BYTE_W-1:0]   r_fill, n_fill;
    logic [BYTE_W-1:0]   r_mark_a, n_mark_a;
    logic [BYTE_W-1:0]   r_mark_b, n_mark_b;
    logic [BYTE_W-1:0]   r_pending, n_pending;
    logic [FRAME_W-1:0]  r_written, n_written;

    t_phase              tok_phase;
    logic                done;
    logic [BYTE_W-1:0]   run_val;
    logic [LEN_W-1:0]    run_cnt;
    logic [FRAME_W-1:0]  remaining;
    logic [LEN_W-1:0]    run_len;
    logic [FRAME_W-1:0]  sum;
    logic                hit_full;

    // token completion and its run before clipping
    always_comb begin
        tok_phase = r_phase;
        n_fill    = r_fill;
        n_mark_a  = r_mark_a;
        n_mark_b  = r_mark_b;
        n_pending = r_pending;
        done      = 1'b0;
        run_val   = i_in_byte;
        run_cnt   = LEN_W'(1);
        unique case (r_phase)
            PH_FILL: begin
                n_fill    = i_in_byte;
                tok_phase = PH_MARK_A;
            end
            PH_MARK_A: begin
                n_mark_a  = i_in_byte;
                tok_phase = PH_MARK_B;
            end
            PH_MARK_B: begin
                n_mark_b  = i_in_byte;
                tok_phase = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (i_in_byte == r_mark_a) begin
                    tok_phase = PH_A_COUNT;
                end else if (i_in_byte == r_mark_b) begin
                    tok_phase = PH_B_COUNT;
                end else begin
                    done = 1'b1;
                end
            end
            PH_A_COUNT: begin
                done    = 1'b1;
                run_val = r_fill;
                run_cnt = {1'b0, i_in_byte} + LEN_W'(1);
            end
            PH_B_COUNT: begin
                n_pending = i_in_byte;
                tok_phase = PH_B_VALUE;
            end
            PH_B_VALUE: begin
                done    = 1'b1;
                run_cnt = {1'b0, r_pending} + LEN_W'(1);
            end
            PH_FULL: begin
                tok_phase = PH_FULL;
            end
            default: begin
                tok_phase = PH_FILL;
            end
        endcase
    end

    // clip against the space left in the frame
    always_comb begin
        n_phase   = tok_phase;
        remaining = (r_written < i_size) ? (i_size - r_written) : '0;
        if ({{(FRAME_W-LEN_W){1'b0}}, run_cnt} < remaining) begin
            run_len = run_cnt;
        end else begin
            run_len = remaining[LEN_W-1:0];
        end
        sum      = r_written + {{(FRAME_W-LEN_W){1'b0}}, run_len};
        hit_full = (sum >= i_size);
        n_written = r_written;

        o_run.emit   = 1'b0;
        o_run.value  = run_val;
        o_run.length = run_len;
        o_run.full   = hit_full;

        if (done) begin
            if (remaining == '0) begin
                n_phase = PH_FULL;
            end else begin
                o_run.emit = 1'b1;
                n_written  = sum;
                n_phase    = hit_full ? PH_FULL : PH_TOKEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_FILL;
            r_written <= '0;
        end else if (i_take) begin
            if (i_stream_end) begin
                r_phase   <= PH_FILL;
                r_written <= '0;
            end else begin
                r_phase   <= n_phase;
                r_written <= n_written;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_fill    <= n_fill;
            r_mark_a  <= n_mark_a;
            r_mark_b  <= n_mark_b;
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tmrle_out.sv
// result register between the token decoder and the output channel
// depends on tmrle_pkg
`default_nettype none

module tmrle_out (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_take,
    input  wire tmrle_pkg::t_run             i_run,
    input  wire logic                        i_out_stall,
    output wire logic                        o_busy,
    output wire logic                        o_out_valid,
    output wire logic [tmrle_pkg::BYTE_W-1:0] o_run_value,
    output wire logic [tmrle_pkg::LEN_W-1:0]  o_run_length,
    output wire logic                        o_frame_full
);
    import tmrle_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_value;
    logic [LEN_W-1:0]  r_length;
    logic              r_full;

    // a held result blocks a new transfer only while the receiver stalls
    assign o_busy = r_valid & i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= i_run.emit;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_run.emit) begin
            r_value  <= i_run.value;
            r_length <= i_run.length;
            r_full   <= i_run.full;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_run_value  = r_value;
    assign o_run_length = r_length;
    assign o_frame_full = r_full;

endmodule

`default_nettype wire

FILE: sim/two_marker_rle_frame_decoder_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for two_marker_rle_frame_decoder
// depends on tmrle_pkg and the decoder rtl; each run transfer is checked against
// the directed table's runs or runs predicted byte by byte from the accepted stream

module two_marker_rle_frame_decoder_tb;
    import tmrle_pkg::*;

    localparam int unsigned FRAME_CAP       = 65536;
    localparam int unsigned IDLE_LIMIT      = 1000;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned ITEMS_PER_PHASE = 76;
    localparam int unsigned MAX_REPORTS     = 20;
    localparam int unsigned N_DIR           = 32;
    localparam logic [2:0]  REG_FRAME_SIZE  = 3'd0;

    typedef enum logic [1:0] {ROW_PRED, ROW_RUN, ROW_NONE, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RX_FREE, RX_HOLD, RX_TOGGLE, RX_COIN} t_rx_mode;

    typedef struct packed {
        t_row_kind    kind;
        logic [16:0]  data;
        logic         last;
        logic [7:0]   value;
        logic [8:0]   length;
        logic         full;
    } t_dir_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [7:0]  i_in_byte    = '0;
    logic        i_stream_end = 1'b0;
    logic        i_out_stall  = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_run_value;
    logic [8:0]  o_run_length;
    logic        o_frame_full;
    logic [31:0] prdata;
    logic        pready;

    two_marker_rle_frame_decoder #(
        .MAX_FRAME_BYTES(FRAME_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_stream_end (i_stream_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_run_value  (o_run_value),
        .o_run_length (o_run_length),
        .o_frame_full (o_frame_full),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    t_dir_row dir_rows [N_DIR] = '{
        // reset frame size, extreme markers and counts
        '{ROW_NONE, 17'h000AA, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00000, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h000FF, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_RUN,  17'h00041, 1'b0, 8'h41, 9'd1,   1'b0},
        '{ROW_NONE, 17'h00000, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_RUN,  17'h000FF, 1'b0, 8'hAA, 9'd256, 1'b0},
        '{ROW_NONE, 17'h000FF, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00000, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_RUN,  17'h00000, 1'b0, 8'h00, 9'd1,   1'b0},
        '{ROW_NONE, 17'h000FF, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h000FF, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_RUN,  17'h000FF, 1'b0, 8'hFF, 9'd256, 1'b0},
        '{ROW_RUN,  17'h0007F, 1'b1, 8'h7F, 9'd1,   1'b0},
        // equal markers, then a token cut short by stream end
        '{ROW_PRED, 17'h00055, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_PRED, 17'h00033, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_PRED, 17'h00033, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_PRED, 17'h00033, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_PRED, 17'h00004, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00033, 1'b1, 8'h00, 9'd0,   1'b0},
        // clipped run fills the frame, later bytes ignored
        '{ROW_CFG,  17'd3,     1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00000, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00001, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00002, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00001, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_RUN,  17'h00009, 1'b0, 8'h00, 9'd3,   1'b1},
        '{ROW_NONE, 17'h00009, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00005, 1'b1, 8'h00, 9'd0,   1'b0},
        // zero frame size: the first token gives nothing
        '{ROW_CFG,  17'd0,     1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00011, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00022, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00033, 1'b0, 8'h00, 9'd0,   1'b0},
        '{ROW_NONE, 17'h00044, 1'b1, 8'h00, 9'd0,   1'b0}
    };

    t_phase      dec_phase;
    logic [7:0]  dec_fill;
    logic [7:0]  dec_mark_a;
    logic [7:0]  dec_mark_b;
    logic [7:0]  dec_count;
    int unsigned dec_written;
    logic [16:0] cfg_frame_size;
    t_run        predicted_runs [$];

    int unsigned n_sent      = 0;
    int unsigned n_decoded   = 0;
    int unsigned n_frames    = 0;
    int unsigned n_runs      = 0;
    int unsigned n_full      = 0;
    int unsigned n_writes    = 0;
    int unsigned n_errors    = 0;
    int unsigned burst_left  = 0;
    int unsigned rx_left     = 0;
    int unsigned idle_cycles = 0;
    t_rx_mode    rx_mode     = RX_FREE;

    function automatic void clear_frame_state();
        dec_phase   = PH_FILL;
        dec_fill    = '0;
        dec_mark_a  = '0;
        dec_mark_b  = '0;
        dec_count   = '0;
        dec_written = 0;
    endfunction

    function automatic bit close_run(input logic [7:0] value, input int unsigned count,
                                     output t_run run);
        int unsigned size;
        int unsigned room;
        int unsigned len;
        run  = '0;
        size = (cfg_frame_size > FRAME_CAP) ? FRAME_CAP : cfg_frame_size;
        room = (dec_written < size) ? size - dec_written : 0;
        if (room == 0) begin
            dec_phase = PH_FULL;
            return 1'b0;
        end
        len = (count < room) ? count : room;
        dec_written += len;
        run.emit   = 1'b1;
        run.value  = value;
        run.length = 9'(len);
        run.full   = (dec_written >= size);
        dec_phase  = run.full ? PH_FULL : PH_TOKEN;
        return 1'b1;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic last, output t_run run);
        bit got;
        got = 1'b0;
        run = '0;
        if (dec_phase != PH_FULL) n_decoded++;
        case (dec_phase)
            PH_FILL: begin
                dec_fill  = b;
                dec_phase = PH_MARK_A;
            end
            PH_MARK_A: begin
                dec_mark_a = b;
                dec_phase  = PH_MARK_B;
            end
            PH_MARK_B: begin
                dec_mark_b = b;
                dec_phase  = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (b == dec_mark_a) dec_phase = PH_A_COUNT;
                else if (b == dec_mark_b) dec_phase = PH_B_COUNT;
                else got = close_run(b, 1, run);
            end
            PH_A_COUNT: got = close_run(dec_fill, int'(b) + 1, run);
            PH_B_COUNT: begin
                dec_count = b;
                dec_phase = PH_B_VALUE;
            end
            PH_B_VALUE: got = close_run(b, int'(dec_count) + 1, run);
            default: ;
        endcase
        if (last) begin
            clear_frame_state();
            n_frames++;
        end
        return got;
    endfunction

    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    // sender: bursts of transfers separated by random gaps
    task automatic send_byte(input logic [7:0] b, input logic last, output t_run run,
                             output bit got);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_in_byte    <= b;
        i_stream_end <= last;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        n_sent++;
        got = decode_byte(b, last, run);
    endtask

    task automatic drain_runs();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (predicted_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_size(input logic [16:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_FRAME_SIZE;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_frame_size = value;
        n_writes++;
    endtask

    task automatic send_random_frame(input int unsigned max_tokens);
        logic [7:0]  seq [$];
        logic [7:0]  mark_a;
        logic [7:0]  mark_b;
        logic [7:0]  lit;
        int unsigned cut;
        t_run        run;
        bit          got;
        mark_a = 8'($urandom);
        mark_b = ($urandom_range(0, 7) == 0) ? mark_a : 8'($urandom);
        seq.push_back(8'($urandom));
        seq.push_back(mark_a);
        seq.push_back(mark_b);
        repeat ($urandom_range(1, max_tokens)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    lit = 8'($urandom);
                    if ((lit == mark_a || lit == mark_b) && $urandom_range(0, 3) != 0)
                        lit = lit + 8'd1;
                    seq.push_back(lit);
                end
                4, 5: begin
                    seq.push_back(mark_a);
                    seq.push_back(pick_count());
                end
                6, 7, 8: begin
                    seq.push_back(mark_b);
                    seq.push_back(pick_count());
                    seq.push_back(8'($urandom));
                end
                default: seq.push_back(8'($urandom));
            endcase
        end
        // some frames are cut short at a random byte, which may fall inside a header or a token
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, seq.size());
            while (seq.size() > cut) void'(seq.pop_back());
        end
        foreach (seq[k]) begin
            send_byte(seq[k], k == seq.size() - 1, run, got);
            if (got) predicted_runs.push_back(run);
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
            RX_FREE:   i_out_stall <= 1'b0;
            RX_HOLD:   i_out_stall <= 1'b1;
            RX_TOGGLE: i_out_stall <= ~i_out_stall;
            default:   i_out_stall <= ($urandom_range(0, 2) == 0);
        endcase
    end

    always @(posedge i_clk) begin : run_check
        t_run want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            n_runs++;
            if (o_frame_full === 1'b1) n_full++;
            if (predicted_runs.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: unexpected run transfer: value %h length %0d full %b",
                             $time, o_run_value, o_run_length, o_frame_full);
            end else begin
                want = predicted_runs.pop_front();
                if ({o_run_value, o_run_length, o_frame_full} !==
                    {want.value, want.length, want.full}) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: run mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 $time, want.value, want.length, want.full,
                                 o_run_value, o_run_length, o_frame_full);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        logic [16:0] sizes [8];
        t_run        run;
        bit          got;
        int unsigned goal;
        clear_frame_state();
        cfg_frame_size = FRAME_SIZE_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain_runs();
                write_frame_size(dir_rows[i].data);
            end else begin
                send_byte(dir_rows[i].data[7:0], dir_rows[i].last, run, got);
                if (dir_rows[i].kind == ROW_RUN)
                    predicted_runs.push_back('{1'b1, dir_rows[i].value,
                                               dir_rows[i].length, dir_rows[i].full});
                else if (dir_rows[i].kind == ROW_PRED && got)
                    predicted_runs.push_back(run);
            end
        end

        // largest, smallest, zero and saturating sizes among the settings
        sizes = '{17'd65536, 17'd1, 17'd0, 17'h1FFFF, 17'd65537,
                  17'($urandom_range(2, 40)), 17'($urandom_range(41, 700)), FRAME_SIZE_RST};
        foreach (sizes[p]) begin
            drain_runs();
            write_frame_size(sizes[p]);
            goal = n_sent + ITEMS_PER_PHASE;
            while (n_sent < goal) send_random_frame((sizes[p] < 41) ? 6 : 30);
        end
        drain_runs();

        $display("sent %0d bytes (%0d decoded) in %0d frames across %0d frame size settings",
                 n_sent, n_decoded, n_frames, n_writes);
        $display("checked %0d runs, %0d of them closing a frame", n_runs, n_full);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tmrle_pkg.sv
rtl/core/tmrle_tok.sv
rtl/core/tmrle_out.sv
rtl/core/two_marker_rle_frame_decoder.sv
sim/two_marker_rle_frame_decoder_tb.sv
